// ===== hdl/bdq_pkg.sv =====
// Shared types and constants for the bounded deque with search.
package bdq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EXT_W = (CNT_W > 7) ? CNT_W : 7;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_FIND       = 3'd2,
    OP_GET        = 3'd3,
    OP_POP_FRONT  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CH_HOLD,
    CH_UP,
    CH_DOWN
  } chain_mode_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [5:0]         position;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic [5:0]         found_position;
    logic signed [31:0] read_word;
    logic [6:0]         entry_count;
  } out_t;

  typedef struct packed {
    chain_mode_t        mode;
    logic               load_en;
    logic [IDX_W-1:0]   load_idx;
    logic signed [31:0] word;
  } chain_ctl_t;

endpackage

// ===== hdl/bdq_cell.sv =====
// One storage cell of the deque chain: holds one entry, shifts to either neighbor.
module bdq_cell (
  input  logic                       clk,
  input  bdq_pkg::chain_mode_t       mode,
  input  logic                       load,
  input  logic signed [31:0]         word,
  input  logic signed [31:0]         lower,
  input  logic signed [31:0]         upper,
  output logic signed [31:0]         data
);
  import bdq_pkg::*;

  logic signed [31:0] data_r;

  always_ff @(posedge clk) begin
    case (mode)
      CH_HOLD: begin
        if (load) begin
          data_r <= word;
        end
      end
      CH_UP:   data_r <= lower;
      CH_DOWN: data_r <= upper;
      default: data_r <= data_r;
    endcase
  end

  assign data = data_r;

endmodule

// ===== hdl/bdq_ctrl.sv =====
// Request sequencer: entry count, rotation scan for find/get, result register.
module bdq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bdq_pkg::in_t        in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bdq_pkg::out_t       out_data,
  input  logic signed [31:0]  head,
  output bdq_pkg::chain_ctl_t ctl
);
  import bdq_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   where_r, where_nxt;
  logic signed [31:0] got_r, got_nxt;
  in_t                req_r, req_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;
  logic               accept;
  logic               res_wr;
  logic               full;
  logic               scan_last;
  logic [EXT_W-1:0]   idx_ext, count_ext, pos_ext, cnt_nxt_ext, where_ext;

  assign accept    = in_valid && in_ready;
  assign full      = (count_r >= CNT_W'(DEPTH));
  assign scan_last = (idx_r == IDX_W'(DEPTH - 1));
  assign idx_ext   = EXT_W'(idx_r);
  assign count_ext = EXT_W'(count_r);
  assign pos_ext   = EXT_W'(req_r.position);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_data.op == OP_FIND || in_data.op == OP_GET)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready    = (state_r == S_IDLE) && (!out_valid_r || out_ready);
    ctl.mode    = CH_HOLD;
    ctl.load_en = 1'b0;
    ctl.load_idx = count_r[IDX_W-1:0];
    ctl.word    = in_data.value;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    hit_nxt     = hit_r;
    where_nxt   = where_r;
    got_nxt     = got_r;
    req_nxt     = req_r;
    res_wr      = 1'b0;
    out_nxt.status    = ST_OK;
    out_nxt.read_word = '0;
    where_ext   = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.op)
            OP_PUSH_BACK: begin
              res_wr = 1'b1;
              if (full) begin
                out_nxt.status = ST_FULL;
              end else begin
                ctl.load_en = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_PUSH_FRONT: begin
              res_wr = 1'b1;
              if (full) begin
                out_nxt.status = ST_FULL;
              end else begin
                ctl.mode = CH_UP;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              res_wr = 1'b1;
              if (count_r == '0) begin
                out_nxt.status = ST_RANGE;
              end else begin
                ctl.mode = CH_DOWN;
                count_nxt = count_r - 1'b1;
              end
            end
            OP_FIND, OP_GET: begin
              req_nxt   = in_data;
              idx_nxt   = '0;
              hit_nxt   = 1'b0;
              where_nxt = '0;
              got_nxt   = '0;
            end
            default: res_wr = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        // full rotation: cell 0 sees entry idx, order is restored when the rotation completes
        ctl.mode = CH_DOWN;
        idx_nxt  = idx_r + 1'b1;
        if (idx_ext < count_ext && !hit_r) begin
          if (req_r.op == OP_FIND && head == req_r.value) begin
            hit_nxt   = 1'b1;
            where_nxt = idx_r;
          end
          if (req_r.op == OP_GET && idx_ext == pos_ext) begin
            hit_nxt = 1'b1;
            got_nxt = head;
          end
        end
        if (scan_last) begin
          res_wr = 1'b1;
          if (req_r.op == OP_FIND) begin
            if (hit_nxt) begin
              where_ext = EXT_W'(where_nxt);
            end else begin
              out_nxt.status = ST_MISSING;
            end
          end else begin
            if (hit_nxt) begin
              out_nxt.read_word = got_nxt;
            end else begin
              out_nxt.status = ST_RANGE;
            end
          end
        end
      end
      default: ;
    endcase

    cnt_nxt_ext            = EXT_W'(count_nxt);
    out_nxt.entry_count    = cnt_nxt_ext[6:0];
    out_nxt.found_position = where_ext[5:0];

    out_valid_nxt = out_valid_r;
    if (res_wr) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    hit_r   <= hit_nxt;
    where_r <= where_nxt;
    got_r   <= got_nxt;
    req_r   <= req_nxt;
    if (res_wr) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/bounded_deque_with_search.sv =====
// Bounded deque with search: top level, chain of entry cells plus sequencer.
// For insert back, insert front, remove front and unused op codes, the result
// is registered at the edge that accepts the item. Find and get use the
// accepting cycle, then one full rotation of the cell chain past cell 0,
// where the single comparator sits; the result is registered at the last
// rotation step. One item is in work at a time, and a new item is accepted
// while the previous result is being taken.
module bounded_deque_with_search (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bdq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bdq_pkg::out_t out_data
);
  import bdq_pkg::*;

  chain_ctl_t         ctl;
  logic signed [31:0] cell_data [DEPTH];

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .head      (cell_data[0]),
    .ctl       (ctl)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    logic               load;

    if (i == 0) begin : g_first
      assign lower = ctl.word;
    end else begin : g_mid
      assign lower = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = cell_data[0];
    end else begin : g_next
      assign upper = cell_data[i+1];
    end

    assign load = ctl.load_en && (ctl.load_idx == IDX_W'(i));

    bdq_cell u_cell (
      .clk   (clk),
      .mode  (ctl.mode),
      .load  (load),
      .word  (ctl.word),
      .lower (lower),
      .upper (upper),
      .data  (cell_data[i])
    );
  end

endmodule

// ===== hdl/bdq_checker.sv =====
// Port-level checks for the bounded deque with search, bound to the top level.
module bdq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input bdq_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input bdq_pkg::out_t out_data
);
  import bdq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.entry_count == 7'(DEPTH))
    else $error("full reported below capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.read_word == '0 && out_data.found_position == '0)
    else $error("failed request carries data");

  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op == OP_PUSH_BACK |=> out_valid)
    else $error("insert at back gave no result in the next cycle");

endmodule

bind bounded_deque_with_search bdq_checker u_bdq_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for bounded_deque_with_search: random and directed requests.
module tb_top;
  import bdq_pkg::*;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_MID   = 3'd6;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam int RANDOM_ITEMS = 550;
  localparam int IDLE_PCT     = 17;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_FROM    = 300;
  localparam int CALM_TO      = 380;
  localparam int TAIL_CYCLES  = 4 * DEPTH;

  typedef struct {
    in_t data;
    bit  drain;
  } request_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_ready = 1'b0;
  in_t  in_data   = '0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  request_t           pending[$];
  out_t               expected_results[$];
  logic signed [31:0] word_pool[$];
  int                 gen_count;
  int                 gen_items;

  logic signed [31:0] shadow_entries [DEPTH];
  int                 shadow_count;

  out_t want;
  int   n_in, n_out, errors;
  int   n_full, n_range, n_missing;
  logic settled = 1'b1;
  logic calm    = 1'b0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left;

  bounded_deque_with_search dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  function automatic out_t deque_predict(in_t req);
    out_t r;
    r = '0;
    r.status = ST_OK;
    case (req.op)
      OP_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = req.value;
          shadow_count++;
        end
      end
      OP_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > 0; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[0] = req.value;
          shadow_count++;
        end
      end
      OP_FIND: begin
        r.status = ST_MISSING;
        for (int i = 0; i < shadow_count; i++) begin
          if (r.status == ST_MISSING && shadow_entries[i] == req.value) begin
            r.status = ST_OK;
            r.found_position = i[5:0];
          end
        end
      end
      OP_GET: begin
        if (int'(req.position) >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          r.read_word = shadow_entries[req.position];
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = ST_RANGE;
        end else begin
          shadow_count--;
          for (int i = 0; i < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
        end
      end
      default: ;
    endcase
    r.entry_count = shadow_count[6:0];
    return r;
  endfunction

  task automatic add_req(logic [2:0] op, logic signed [31:0] word, logic [5:0] pos);
    request_t r;
    r.data.op       = op;
    r.data.value    = word;
    r.data.position = pos;
    r.drain         = 1'b0;
    pending.push_back(r);
    gen_items++;
    if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
      if (gen_count < DEPTH) begin
        gen_count++;
        word_pool.push_back(word);
        if (word_pool.size() > 16) void'(word_pool.pop_front());
      end
    end else if (op == OP_POP_FRONT) begin
      if (gen_count > 0) gen_count--;
    end
  endtask

  task automatic add_drain();
    request_t r;
    r.data  = '0;
    r.drain = 1'b1;
    pending.push_back(r);
  endtask

  function automatic logic signed [31:0] pick_word();
    logic signed [31:0] w;
    case ($urandom_range(3))
      0: w = $urandom;
      1: w = (word_pool.size() > 0) ? word_pool[$urandom_range(word_pool.size() - 1)] : $urandom;
      2: w = $signed($urandom_range(7)) - 32'sd3;
      default: begin
        case ($urandom_range(3))
          0: w = 32'sh7fffffff;
          1: w = 32'sh80000000;
          2: w = 32'sh0;
          default: w = -32'sd1;
        endcase
      end
    endcase
    return w;
  endfunction

  function automatic logic [5:0] pick_position();
    if (gen_count > 0 && $urandom_range(3) != 0) return 6'($urandom_range(gen_count - 1));
    return 6'($urandom_range(63));
  endfunction

  function automatic logic [2:0] pick_push();
    return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
  endfunction

  task automatic fill_episode();
    while (gen_count < DEPTH) add_req(pick_push(), pick_word(), 6'd0);
    add_req(OP_PUSH_BACK, pick_word(), 6'd0);
    add_req(OP_PUSH_FRONT, pick_word(), 6'd0);
    add_req(OP_GET, pick_word(), 6'd63);
    add_req(OP_GET, pick_word(), pick_position());
    add_req(OP_FIND, pick_word(), 6'd0);
    add_req(OP_FIND, $urandom, 6'd0);
  endtask

  task automatic drain_episode();
    while (gen_count > 0) begin
      add_req(OP_POP_FRONT, pick_word(), pick_position());
      if ($urandom_range(7) == 0) add_req(OP_FIND, pick_word(), 6'd0);
    end
    add_req(OP_POP_FRONT, pick_word(), 6'd0);
    add_req(OP_GET, pick_word(), 6'd0);
  endtask

  task automatic mixed_episode(int len);
    int k;
    for (int n = 0; n < len; n++) begin
      k = $urandom_range(99);
      if (k < 18)      add_req(OP_PUSH_BACK, pick_word(), pick_position());
      else if (k < 34) add_req(OP_PUSH_FRONT, pick_word(), pick_position());
      else if (k < 56) add_req(OP_FIND, pick_word(), pick_position());
      else if (k < 78) add_req(OP_GET, pick_word(), pick_position());
      else if (k < 95) add_req(OP_POP_FRONT, pick_word(), pick_position());
      else add_req(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), $urandom, pick_position());
    end
  endtask

  task automatic noise_episode(int len);
    for (int n = 0; n < len; n++) add_req(3'($urandom_range(7)), $urandom, 6'($urandom_range(63)));
  endtask

  task automatic build_stimulus();
    int start;
    add_req(OP_GET, 32'sd0, 6'd0);
    add_req(OP_FIND, 32'sd0, 6'd0);
    add_req(OP_POP_FRONT, 32'sd0, 6'd0);
    add_req(OP_PUSH_BACK, 32'sh7fffffff, 6'd63);
    add_req(OP_PUSH_BACK, 32'sh80000000, 6'd0);
    add_req(OP_PUSH_FRONT, 32'sd0, 6'd0);
    add_req(OP_PUSH_FRONT, -32'sd1, 6'd0);
    add_req(OP_PUSH_BACK, -32'sd1, 6'd0);
    add_req(OP_FIND, -32'sd1, 6'd0);
    add_req(OP_FIND, 32'sh80000000, 6'd0);
    add_req(OP_FIND, 32'sh00012345, 6'd0);
    add_req(OP_GET, 32'sd0, 6'd0);
    add_req(OP_GET, 32'sd0, 6'd4);
    add_req(OP_GET, 32'sd0, 6'd5);
    add_req(OP_GET, 32'sd0, 6'd63);
    add_req(OP_SPARE_FIRST, 32'sh80000000, 6'd63);
    add_req(OP_SPARE_MID, $urandom, 6'd21);
    add_req(OP_SPARE_LAST, 32'sh7fffffff, 6'd0);
    add_req(OP_POP_FRONT, 32'sd0, 6'd0);
    add_req(OP_FIND, -32'sd1, 6'd0);
    add_req(OP_GET, 32'sd0, 6'd3);
    add_drain();
    start = gen_items;
    fill_episode();
    drain_episode();
    while (gen_items - start < RANDOM_ITEMS) begin
      case ($urandom_range(15))
        0:       fill_episode();
        1, 2:    drain_episode();
        3:       noise_episode(8);
        default: mixed_episode(12);
      endcase
      if (gen_items - start > 400 && gen_items - start < 420) add_drain();
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending.size() > 0 && pending[0].drain) begin
        in_valid <= 1'b0;
        if (!in_valid && settled) void'(pending.pop_front());
      end else if (pending.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_data  <= pending[0].data;
        void'(pending.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = deque_predict(in_data);
        expected_results.push_back(want);
        n_in++;
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_RANGE) n_range++;
        if (want.status == ST_MISSING) n_missing++;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: status %0d count %0d",
                 out_data.status, out_data.entry_count);
          errors++;
        end else begin
          want = expected_results.pop_front();
          n_out++;
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.found_position !== want.found_position) begin
            $error("found_position: expected %0d, got %0d",
                   want.found_position, out_data.found_position);
            errors++;
          end
          if (out_data.read_word !== want.read_word) begin
            $error("read_word: expected %0d, got %0d", want.read_word, out_data.read_word);
            errors++;
          end
          if (out_data.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d",
                   want.entry_count, out_data.entry_count);
            errors++;
          end
        end
      end
    end
    settled <= (expected_results.size() == 0);
    calm    <= (n_in >= CALM_FROM && n_in < CALM_TO);
    if (n_in >= HOLD_AT) hold_go <= 1'b1;
  end

  initial begin
    shadow_count = 0;
    for (int i = 0; i < DEPTH; i++) shadow_entries[i] = '0;
    build_stimulus();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (pending.size() != 0 || in_valid || expected_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      errors++;
    end
    $display("Checked %0d requests and %0d results, %0d mismatches.", n_in, n_out, errors);
    $display("Seen: %0d full inserts, %0d empty/range, %0d failed finds; output hold %0d cycles.",
             n_full, n_range, n_missing, HOLD_CYCLES);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d requests pending.", pending.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
